// File: design/fhra_pkg.sv
// Shared types, codes and sizes of the recycling handle allocator.
`default_nettype none

package fhra_pkg;

  localparam int HANDLE_W          = 8;
  localparam int HANDLE_DEPTH      = 256;
  localparam int COUNT_W           = 9;
  localparam int POOL_SIZE_DEFAULT = 256;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_TRY   = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE_FREED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC  = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [HANDLE_W-1:0] release_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    logic [1:0]          status;
  } rsp_t;

  typedef struct packed {
    logic                pop;
    logic                push;
    logic [HANDLE_W-1:0] push_data;
  } fifo_ctl_t;

  typedef struct packed {
    logic                en;
    logic [HANDLE_W-1:0] addr;
    logic                data;
  } map_wr_t;

endpackage

`default_nettype wire

// File: design/fifo_recycling_handle_allocator_unit.sv
// Top level of the recycling handle allocator: command sequencing and result register.
//
//   Channel   Ports              Beat marked by       Payload
//   command   start, busy, req   start high, busy low req_t (cmd, release_handle)
//   result    done, rsp          done high            rsp_t (granted_handle, status)
//
// For each command, the accepting edge reads the freed queue head and the
// bitmap entry, and the next edge writes both memories back and registers the result.
// The result shows on rsp for one cycle, starting at the edge that registers it.
// After reset, busy stays high while the bitmap memory is swept to zero.
// The receiver cannot stall; busy is the only back pressure.
`default_nettype none

module fifo_recycling_handle_allocator_unit
  import fhra_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam int HANDLE_SPACE = (POOL_SIZE < HANDLE_DEPTH) ? POOL_SIZE : HANDLE_DEPTH;
  localparam logic [COUNT_W-1:0] SPACE_LIMIT = COUNT_W'(HANDLE_SPACE);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  req_t                req_q;
  logic [COUNT_W-1:0]  next_fresh;
  logic [COUNT_W-1:0]  next_fresh_next;
  logic                done_next;
  rsp_t                rsp_next;
  fifo_ctl_t           fifo_ctl;
  map_wr_t             map_wr;
  logic                fifo_empty;
  logic [HANDLE_W-1:0] fifo_head_data;
  logic                map_rd_data;
  logic                clearing;
  logic                accept;

  fhra_free_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .empty     (fifo_empty),
    .head_data (fifo_head_data)
  );

  fhra_alloc_map u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (req.release_handle),
    .wr       (map_wr),
    .rd_data  (map_rd_data),
    .clearing (clearing)
  );

  assign busy   = clearing || (state == S_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_next      = state;
    next_fresh_next = next_fresh;
    done_next       = 1'b0;
    rsp_next        = '{granted_handle: '0, status: ST_OK};
    fifo_ctl        = '{pop: 1'b0, push: 1'b0, push_data: req_q.release_handle};
    map_wr          = '{en: 1'b0, addr: req_q.release_handle, data: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        priority if (req_q.cmd == CMD_ALLOC || req_q.cmd == CMD_TRY) begin
          priority if (!fifo_empty) begin
            rsp_next.granted_handle = fifo_head_data;
            fifo_ctl.pop            = 1'b1;
            map_wr                  = '{en: 1'b1, addr: fifo_head_data, data: 1'b1};
          end else if (req_q.cmd == CMD_TRY) begin
            rsp_next.status = ST_NONE_FREED;
          end else if (next_fresh < SPACE_LIMIT) begin
            rsp_next.granted_handle = next_fresh[HANDLE_W-1:0];
            next_fresh_next         = next_fresh + 1'b1;
            map_wr                  = '{en: 1'b1, addr: next_fresh[HANDLE_W-1:0], data: 1'b1};
          end else begin
            rsp_next.status = ST_EXHAUSTED;
          end
        end else if (req_q.cmd == CMD_FREE) begin
          if (!map_rd_data) begin
            rsp_next.status = ST_NOT_ALLOC;
          end else begin
            fifo_ctl.push = 1'b1;
            map_wr.en     = 1'b1;
          end
        end else begin
          rsp_next.status = ST_OK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_fresh <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      next_fresh <= next_fresh_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// File: design/fhra_free_fifo.sv
// Queue of freed handles held in a synchronous memory with head, tail and fill count.
`default_nettype none

module fhra_free_fifo
  import fhra_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fifo_ctl_t           ctl,
  output logic                     empty,
  output logic [HANDLE_W-1:0]      head_data
);

  logic [HANDLE_W-1:0] mem [HANDLE_DEPTH];
  logic [HANDLE_W-1:0] head;
  logic [HANDLE_W-1:0] tail;
  logic [COUNT_W-1:0]  count;

  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.push_data;
    end
    head_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.pop) begin
        head  <= head + 1'b1;
        count <= count - 1'b1;
      end else if (ctl.push) begin
        tail  <= tail + 1'b1;
        count <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/fhra_alloc_map.sv
// Allocated bitmap in a synchronous memory, swept to zero after reset.
`default_nettype none

module fhra_alloc_map
  import fhra_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [HANDLE_W-1:0] rd_addr,
  input  wire map_wr_t             wr,
  output logic                     rd_data,
  output logic                     clearing
);

  logic                mem [HANDLE_DEPTH];
  logic [HANDLE_W-1:0] clr_addr;
  logic                wr_en;
  logic [HANDLE_W-1:0] wr_addr;
  logic                wr_data;

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = 1'b0;
    end else begin
      wr_en   = wr.en;
      wr_addr = wr.addr;
      wr_data = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == HANDLE_W'(HANDLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the recycling handle allocator: command, free and recycle traffic.
`default_nettype none

module testbench;
  import fhra_pkg::*;

  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam int         HANDLE_SPAN = POOL_SIZE_DEFAULT < 256 ? POOL_SIZE_DEFAULT : 256;
  localparam int         RANDOM_BEATS = 1050;
  localparam int         CYCLE_LIMIT  = 200000;

  typedef logic [HANDLE_W-1:0] handle_q_t[$];

  class handle_grant_tracker;
    logic [HANDLE_W-1:0] recycled[$];
    bit                  in_use[HANDLE_DEPTH];
    logic [COUNT_W-1:0]  fresh_next = '0;
    rsp_t                pending_grants[$];
    int                  errors = 0;

    function void note_command(req_t r);
      rsp_t e;
      e = '0;
      e.status = ST_OK;
      if (r.cmd == CMD_ALLOC || r.cmd == CMD_TRY) begin
        if (recycled.size() != 0) begin
          e.granted_handle = recycled.pop_front();
          in_use[e.granted_handle] = 1'b1;
        end else if (r.cmd == CMD_TRY) begin
          e.status = ST_NONE_FREED;
        end else if (fresh_next < HANDLE_SPAN) begin
          e.granted_handle = fresh_next[HANDLE_W-1:0];
          fresh_next = fresh_next + 1'b1;
          in_use[e.granted_handle] = 1'b1;
        end else begin
          e.status = ST_EXHAUSTED;
        end
      end else if (r.cmd == CMD_FREE) begin
        if (!in_use[r.release_handle]) begin
          e.status = ST_NOT_ALLOC;
        end else begin
          recycled.push_back(r.release_handle);
          in_use[r.release_handle] = 1'b0;
        end
      end
      pending_grants.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_grants.size() == 0) begin
        $error("unexpected result beat: granted_handle %0d, status %0d",
               got.granted_handle, got.status);
        errors++;
        return;
      end
      e = pending_grants.pop_front();
      if (got.granted_handle !== e.granted_handle) begin
        $error("granted_handle mismatch: expected %0d, actual %0d",
               e.granted_handle, got.granted_handle);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_grants.size();
    endfunction

    function handle_q_t allocated_handles();
      handle_q_t hs;
      for (int i = 0; i < HANDLE_DEPTH; i++) begin
        if (in_use[i]) hs.push_back(i[HANDLE_W-1:0]);
      end
      return hs;
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  handle_grant_tracker tracker;
  int unsigned         cycle_count = 0;
  int                  issued = 0;
  bit                  steady = 1'b0;

  fifo_recycling_handle_allocator_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fifo_recycling_handle_allocator_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_result(rsp);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  task automatic issue(input logic [1:0] c, input logic [HANDLE_W-1:0] h);
    req_t          r;
    logic [9:0]    noise;
    int unsigned   gap;
    r.cmd = c;
    r.release_handle = h;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_command(r);
    issued++;
    gap = pick_gap();
    if (gap != 0) begin
      noise = 10'($urandom);
      start <= 1'b0;
      req <= noise;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_mixed();
    int unsigned roll;
    handle_q_t   owned;
    roll = $urandom_range(99, 0);
    owned = tracker.allocated_handles();
    if (roll < 30) begin
      issue(CMD_ALLOC, HANDLE_W'($urandom));
    end else if (roll < 50) begin
      issue(CMD_TRY, HANDLE_W'($urandom));
    end else if (roll < 80 && owned.size() != 0) begin
      issue(CMD_FREE, owned[$urandom_range(owned.size() - 1, 0)]);
    end else if (roll < 95) begin
      issue(CMD_FREE, HANDLE_W'($urandom));
    end else begin
      issue(CMD_NOP, HANDLE_W'($urandom));
    end
  endtask

  initial begin
    handle_q_t           owned;
    int                  j;
    logic [HANDLE_W-1:0] tmp;
    int unsigned         burst_len;
    tracker = new;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty pool, bad frees, the unused command, recycling order and double free.
    issue(CMD_TRY,   8'h00);
    issue(CMD_FREE,  8'h00);
    issue(CMD_FREE,  8'hFF);
    issue(CMD_NOP,   8'hFF);
    issue(CMD_ALLOC, 8'hFF);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_ALLOC, 8'h55);
    issue(CMD_FREE,  8'h01);
    issue(CMD_FREE,  8'h01);
    issue(CMD_FREE,  8'h00);
    issue(CMD_TRY,   8'hAA);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_TRY,   8'hFF);
    issue(CMD_FREE,  8'h03);
    issue(CMD_FREE,  8'h02);
    issue(CMD_NOP,   8'h00);
    issue(CMD_ALLOC, 8'h00);

    // Drain the fresh handles well past exhaustion.
    steady = ($urandom_range(3, 0) == 0);
    repeat (280) issue(($urandom_range(99, 0) < 8) ? CMD_TRY : CMD_ALLOC,
                       HANDLE_W'($urandom));

    // Return every handle in random order so the freed queue fills and wraps.
    owned = tracker.allocated_handles();
    for (int i = owned.size() - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = owned[i];
      owned[i] = owned[j];
      owned[j] = tmp;
    end
    steady = 1'b0;
    foreach (owned[i]) begin
      if ($urandom_range(9, 0) == 0) issue(($urandom_range(1, 0) != 0) ? CMD_FREE : CMD_NOP,
                                           HANDLE_W'($urandom));
      issue(CMD_FREE, owned[i]);
    end

    while (issued < RANDOM_BEATS + 17) begin
      steady = ($urandom_range(4, 0) == 0);
      burst_len = $urandom_range(40, 10);
      repeat (burst_len) issue_mixed();
    end

    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("fifo_recycling_handle_allocator_unit regression: pass");
    end else begin
      $display("fifo_recycling_handle_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
